>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tlbl_pkg.sv
// ----------------------------------------------------------------------------
// tlbl_pkg
// Shared constants and command/status types of the translation block.
// ----------------------------------------------------------------------------
package tlbl_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int NUM_FRAMES  = 128;
    localparam int OFFSET_BITS = 8;
    localparam int AGE_BITS    = 16;

    localparam int ADDR_W = 16;
    localparam int PAGE_W = 8;
    localparam int PA_W   = 15;
    localparam int LF_W   = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new address
        logic lookup;  // resolve the page, register the result, update TLB, frame tables and count
        logic scan;    // step the frame search/victim scan
        logic scan_start;
    } tlbl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tlb_hit;
        logic scan_done;
    } tlbl_sts_t;

endpackage

>>> rtl/core/tlb_translate_lru_frames.sv
// ----------------------------------------------------------------------------
// tlb_translate_lru_frames
// Address translation with FIFO-refilled TLB and LRU frame replacement.
// ----------------------------------------------------------------------------
// Usage: a logical address enters on the s_axis channel (tdata = page:offset)
// and one result leaves on m_axis per address: the physical address in tdata
// and the hit, fault, load page and load frame flags in tuser.
// On a TLB hit the controller skips the scan and the result is registered
// in the done state; a new address is not taken while one is in flight. A
// TLB miss walks the frame table one frame per cycle through registered-read
// tables (search and oldest-frame pick share that scan): the scan stops once
// the page is found, or with a fault after the last frame. The next address
// is taken once the previous one has been written into the output register.
// Reset clears the TLB, the frame valid bits, the frame count and the
// translation counter; the page and time-stamp tables are not cleared, since
// only frames marked valid are ever read from them.
// If the receiver stalls, the result holds in the output register, one more
// item may finish its lookup and then waits for the register to drain.
// ----------------------------------------------------------------------------
module tlb_translate_lru_frames #(
    parameter int TLB_ENTRIES = tlbl_pkg::TLB_ENTRIES,
    parameter int NUM_FRAMES  = tlbl_pkg::NUM_FRAMES,
    parameter int OFFSET_BITS = tlbl_pkg::OFFSET_BITS,
    parameter int AGE_BITS    = tlbl_pkg::AGE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] logical_address
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [14:0] physical_address, [15] zero
    output logic [16:0] m_axis_tuser    // [0] tlb_hit, [1] page_fault,
                                        // [9:2] load_page, [16:10] load_frame
);
    tlbl_pkg::tlbl_cmd_t cmd;
    tlbl_pkg::tlbl_sts_t sts;
    logic [tlbl_pkg::PA_W-1:0]   pa;
    logic                        hit;
    logic                        fault;
    logic [tlbl_pkg::PAGE_W-1:0] lpage;
    logic [tlbl_pkg::LF_W-1:0]   lframe;

    tlbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tlbl_dp #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .NUM_FRAMES  (NUM_FRAMES),
        .OFFSET_BITS (OFFSET_BITS),
        .AGE_BITS    (AGE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .addr_in          (s_axis_tdata),
        .physical_address (pa),
        .tlb_hit          (hit),
        .page_fault       (fault),
        .load_page        (lpage),
        .load_frame       (lframe)
    );

    assign m_axis_tdata = {1'b0, pa};
    assign m_axis_tuser = {lframe, lpage, fault, hit};
endmodule

>>> rtl/core/tlbl_dp.sv
// ----------------------------------------------------------------------------
// tlbl_dp
// Datapath: TLB, frame table with time stamps, sequential frame/victim scan.
// ----------------------------------------------------------------------------
module tlbl_dp #(
    parameter int TLB_ENTRIES = tlbl_pkg::TLB_ENTRIES,
    parameter int NUM_FRAMES  = tlbl_pkg::NUM_FRAMES,
    parameter int OFFSET_BITS = tlbl_pkg::OFFSET_BITS,
    parameter int AGE_BITS    = tlbl_pkg::AGE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlbl_pkg::tlbl_cmd_t           cmd,
    output tlbl_pkg::tlbl_sts_t           sts,
    input  logic [tlbl_pkg::ADDR_W-1:0]   addr_in,
    output logic [tlbl_pkg::PA_W-1:0]     physical_address,
    output logic                          tlb_hit,
    output logic                          page_fault,
    output logic [tlbl_pkg::PAGE_W-1:0]   load_page,
    output logic [tlbl_pkg::LF_W-1:0]     load_frame
);
    localparam int TI_W    = $clog2(TLB_ENTRIES);
    localparam int FI_W    = $clog2(NUM_FRAMES);
    localparam int PG_W    = tlbl_pkg::ADDR_W - OFFSET_BITS;
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
    localparam int STAMP_W = 48;
    localparam logic [AGE_BITS-1:0] AGE_MAX    = '1;
    localparam logic [FI_W-1:0]     LAST_FRAME = FI_W'(NUM_FRAMES - 1);

    logic [tlbl_pkg::ADDR_W-1:0] addr_reg;
    logic [TLB_ENTRIES-1:0]      tlb_valid_reg;
    logic [PG_W-1:0]             tlb_page_reg [TLB_ENTRIES];
    logic [FI_W-1:0]             tlb_frame_reg [TLB_ENTRIES];
    logic [TI_W-1:0]             fill_ptr_reg;
    logic [NUM_FRAMES-1:0]       frame_valid_reg;
    logic [CNT_W-1:0]            frames_used_reg;
    logic [STAMP_W-1:0]          xlat_count_reg;
    logic [STAMP_W-1:0]          xlat_count_next;

    // Scan state: read pointer, check stage, found-in-table result and
    // running oldest frame.
    logic                        rd_en_reg;
    logic [FI_W-1:0]             rd_idx_reg;
    logic                        chk_en_reg;
    logic [FI_W-1:0]             chk_idx_reg;
    logic                        found_reg;
    logic [FI_W-1:0]             found_frame_reg;
    logic [FI_W-1:0]             best_reg;
    logic [AGE_BITS-1:0]         best_age_reg;

    logic [PG_W-1:0]        page;
    logic                   hit;
    logic [FI_W-1:0]        hit_frame;
    logic [FI_W-1:0]        frame_sel;
    logic                   fault;
    logic                   page_we;
    logic [PG_W-1:0]        frame_page_rd;
    logic [STAMP_W-1:0]     stamp_rd;
    logic [STAMP_W-1:0]     stamp_diff;
    logic [AGE_BITS-1:0]    chk_age;
    logic                   chk_match;

    assign page            = addr_reg[tlbl_pkg::ADDR_W-1:OFFSET_BITS];
    assign xlat_count_next = xlat_count_reg + 1'b1;
    assign page_we         = cmd.lookup && fault;

    // A frame's age is the number of translations since it was last used,
    // taken from its stamp and saturated to the age width.
    tlbl_ram #(
        .WIDTH (PG_W),
        .DEPTH (NUM_FRAMES)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (frame_sel),
        .wdata (page),
        .raddr (rd_idx_reg),
        .rdata (frame_page_rd)
    );

    tlbl_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (NUM_FRAMES)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (cmd.lookup),
        .waddr (frame_sel),
        .wdata (xlat_count_next),
        .raddr (rd_idx_reg),
        .rdata (stamp_rd)
    );

    assign stamp_diff = xlat_count_reg - stamp_rd;
    assign chk_match  = frame_valid_reg[chk_idx_reg] && (frame_page_rd == page);

    always_comb
    begin
        if (!frame_valid_reg[chk_idx_reg])
            chk_age = '0;
        else if (stamp_diff[STAMP_W-1:AGE_BITS] != '0)
            chk_age = AGE_MAX;
        else
            chk_age = stamp_diff[AGE_BITS-1:0];
    end

    always_comb
    begin
        hit = 1'b0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && tlb_page_reg[i] == page)
            begin
                hit = 1'b1;
                hit_frame = tlb_frame_reg[i];
            end
        end
    end

    assign fault = !hit && !found_reg;

    always_comb
    begin
        if (hit)
            frame_sel = hit_frame;
        else if (found_reg)
            frame_sel = found_frame_reg;
        else if (frames_used_reg < CNT_W'(NUM_FRAMES))
            frame_sel = frames_used_reg[FI_W-1:0];
        else
            frame_sel = best_reg;
    end

    assign sts.tlb_hit   = hit;
    assign sts.scan_done = found_reg || (chk_en_reg && chk_idx_reg == LAST_FRAME);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            addr_reg <= addr_in;
        if (cmd.scan_start)
        begin
            rd_en_reg       <= 1'b1;
            rd_idx_reg      <= '0;
            chk_en_reg      <= 1'b0;
            chk_idx_reg     <= '0;
            found_reg       <= 1'b0;
            found_frame_reg <= '0;
            best_reg        <= '0;
            best_age_reg    <= '0;
        end
        else if (cmd.scan)
        begin
            // Table data is registered in the RAM, so the check stage lags the read pointer.
            chk_en_reg  <= rd_en_reg;
            chk_idx_reg <= rd_idx_reg;
            if (rd_en_reg)
            begin
                if (rd_idx_reg == LAST_FRAME)
                    rd_en_reg <= 1'b0;
                else
                    rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (chk_en_reg)
            begin
                if (chk_match && !found_reg)
                begin
                    found_reg       <= 1'b1;
                    found_frame_reg <= chk_idx_reg;
                end
                if (chk_age > best_age_reg)
                begin
                    best_reg     <= chk_idx_reg;
                    best_age_reg <= chk_age;
                end
            end
        end
        if (cmd.lookup)
        begin
            physical_address <= tlbl_pkg::PA_W'(({{(32-FI_W){1'b0}}, frame_sel} << OFFSET_BITS)
                | {{(32-OFFSET_BITS){1'b0}}, addr_reg[OFFSET_BITS-1:0]});
            tlb_hit    <= hit;
            page_fault <= fault;
            load_page  <= fault ? tlbl_pkg::PAGE_W'(page) : '0;
            load_frame <= fault ? tlbl_pkg::LF_W'(frame_sel) : '0;
            if (!hit)
            begin
                tlb_page_reg[fill_ptr_reg]  <= page;
                tlb_frame_reg[fill_ptr_reg] <= frame_sel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg   <= '0;
            fill_ptr_reg    <= '0;
            frame_valid_reg <= '0;
            frames_used_reg <= '0;
            xlat_count_reg  <= '0;
        end
        else if (cmd.lookup)
        begin
            xlat_count_reg <= xlat_count_next;
            if (fault)
            begin
                if (frames_used_reg < CNT_W'(NUM_FRAMES))
                    frames_used_reg <= frames_used_reg + 1'b1;
                frame_valid_reg[frame_sel] <= 1'b1;
            end
            if (!hit)
            begin
                // Evicted page's TLB entries go away before the refill lands.
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (fault && frames_used_reg >= CNT_W'(NUM_FRAMES)
                        && tlb_frame_reg[i] == frame_sel)
                        tlb_valid_reg[i] <= 1'b0;
                tlb_valid_reg[fill_ptr_reg] <= 1'b1;
                fill_ptr_reg <= (fill_ptr_reg == TI_W'(TLB_ENTRIES - 1))
                    ? '0 : fill_ptr_reg + 1'b1;
            end
        end
    end
endmodule

// ----------------------------------------------------------------------------
// tlbl_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module tlbl_ram #(
    parameter int WIDTH = tlbl_pkg::PAGE_W,
    parameter int DEPTH = tlbl_pkg::NUM_FRAMES
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end
endmodule

>>> rtl/core/tlbl_ctrl.sv
// ----------------------------------------------------------------------------
// tlbl_ctrl
// Controller: handshakes and sequencing of the lookup and scan.
// ----------------------------------------------------------------------------
module tlbl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tlbl_pkg::tlbl_cmd_t cmd,
    input  tlbl_pkg::tlbl_sts_t sts
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TLB  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // A new item may enter whenever no lookup is running; a waiting result
    // only holds the next item back in the done state.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TLB;
                end
            end
            ST_TLB:
            begin
                if (sts.tlb_hit)
                    state_next = ST_DONE;
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.lookup     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

>>> rtl/core/tlbl_checker.sv
// ----------------------------------------------------------------------------
// tlbl_checker
// Port-level checks of the translation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlbl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [16:0] m_axis_tuser
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result changed")
    `ASSERT_IMPL(a_hit_no_fault, clk, rst_n, m_axis_tvalid,
        !(m_axis_tuser[0] && m_axis_tuser[1]), "hit and fault together")
    `ASSERT_IMPL(a_no_fault_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[1],
        m_axis_tuser[16:2] == 15'd0, "load fields set without fault")
    `ASSERT_IMPL(a_fault_frame, clk, rst_n, m_axis_tvalid && m_axis_tuser[1],
        m_axis_tuser[16:10] == m_axis_tdata[14:8], "load frame mismatch")
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "second item taken during lookup")
endmodule

bind tlb_translate_lru_frames tlbl_checker u_tlbl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
